// ----- hdl/tlcs_pkg.sv -----
// Types and constants shared by the timed lock call sequencer.
package tlcs_pkg;

	localparam int CFG_W = 24;
	localparam int CNT_W = 32;
	localparam int MIN_W = 16;

	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_WAIT = 2'd1;
	localparam logic [1:0] PH_RUN  = 2'd2;
	localparam logic [1:0] PH_CALL = 2'd3;

	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_DIAL   = 2'd1;
	localparam logic [1:0] EV_HANGUP = 2'd2;

	localparam logic [1:0] REG_LOCK_TO   = 2'd0;
	localparam logic [1:0] REG_UNLOCK_TO = 2'd1;
	localparam logic [1:0] REG_HANGUP_TO = 2'd2;

	localparam logic [CFG_W-1:0] LOCK_TO_RST   = 24'd1200000;
	localparam logic [CFG_W-1:0] UNLOCK_TO_RST = 24'd120000;
	localparam logic [CFG_W-1:0] HANGUP_TO_RST = 24'd20000;

	localparam logic [CNT_W-1:0] MS_PER_MIN = 32'd60000;

	// floor(n / 60000) = floor((n >> 5) * RECIP >> DIV_SHIFT) for all 32-bit n
	localparam int          DIV_PRE   = 5;
	localparam int          DIV_SHIFT = 38;
	localparam logic [27:0] RECIP     = 28'd146601551;

	typedef struct packed {
		logic [CFG_W-1:0] lock_to;
		logic [CFG_W-1:0] unlock_to;
		logic [CFG_W-1:0] hangup_to;
	} cfg_t;

	typedef struct packed {
		logic       output_on;
		logic       led_green;
		logic       led_orange;
		logic       led_red;
		logic [1:0] modem_event;
		logic       program_active;
	} res_t;

endpackage

// ----- hdl/tlcs_step.sv -----
// Sequencer state and per-tick phase update with its result register.
module tlcs_step (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  tlcs_pkg::cfg_t            cfg,
	input  logic [1:0]                cmd_s1,
	input  logic [tlcs_pkg::CNT_W-1:0] dur_ms_s1,
	input  logic                      locked_s1,
	output tlcs_pkg::res_t            res_s2,
	output logic [tlcs_pkg::CNT_W-1:0] diff_s2
);
	import tlcs_pkg::*;

	logic [1:0]       ph_q;
	logic             start_q;
	logic             stop_q;
	logic [CNT_W-1:0] run_ms_q;
	logic [CNT_W-1:0] pe_q;
	logic [CNT_W-1:0] ue_q;
	logic             out_q;
	logic             grn_q;
	logic             org_q;
	logic             red_q;

	logic [1:0]       ph_n;
	logic             start_n;
	logic             stop_n;
	logic [CNT_W-1:0] run_ms_n;
	logic [CNT_W-1:0] pe_n;
	logic [CNT_W-1:0] ue_n;
	logic             out_n;
	logic             grn_n;
	logic             org_n;
	logic             red_n;
	logic [1:0]       ev_n;

	always_comb begin
		ph_n     = ph_q;
		start_n  = start_q;
		stop_n   = stop_q;
		run_ms_n = run_ms_q;
		pe_n     = (&pe_q) ? pe_q : pe_q + 1'b1;
		ue_n     = (&ue_q) ? ue_q : ue_q + 1'b1;
		out_n    = out_q;
		grn_n    = grn_q;
		org_n    = org_q;
		red_n    = red_q;
		ev_n     = EV_NONE;

		if (cmd_s1 == CMD_START) begin
			run_ms_n = dur_ms_s1;
			start_n  = 1'b1;
		end else if (cmd_s1 == CMD_STOP) begin
			stop_n = 1'b1;
		end

		if (ph_n == PH_IDLE && start_n) begin
			stop_n = 1'b0;
			grn_n  = 1'b1;
			ph_n   = PH_WAIT;
			pe_n   = '0;
		end

		if (ph_n == PH_WAIT) begin
			if (stop_n || pe_n >= CNT_W'(cfg.lock_to)) begin
				out_n   = 1'b0;
				grn_n   = 1'b0;
				org_n   = 1'b0;
				red_n   = 1'b0;
				ph_n    = PH_IDLE;
				start_n = 1'b0;
				stop_n  = 1'b0;
			end else if (locked_s1) begin
				ph_n  = PH_RUN;
				org_n = 1'b1;
				pe_n  = '0;
				ue_n  = '0;
			end
		end

		if (ph_n == PH_RUN) begin
			if (stop_n) begin
				out_n   = 1'b0;
				grn_n   = 1'b0;
				org_n   = 1'b0;
				red_n   = 1'b0;
				ph_n    = PH_IDLE;
				start_n = 1'b0;
				stop_n  = 1'b0;
			end else begin
				out_n = locked_s1;
				if (locked_s1) begin
					ue_n  = '0;
					red_n = 1'b1;
				end
				if (pe_n >= run_ms_n || ue_n >= CNT_W'(cfg.unlock_to)) begin
					out_n = 1'b0;
					grn_n = 1'b0;
					org_n = 1'b0;
					red_n = 1'b0;
					ev_n  = EV_DIAL;
					pe_n  = '0;
					ph_n  = PH_CALL;
				end
			end
		end else if (ph_n == PH_CALL) begin
			if (pe_n >= CNT_W'(cfg.hangup_to)) begin
				ev_n    = EV_HANGUP;
				start_n = 1'b0;
				ph_n    = PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= PH_IDLE;
			start_q  <= 1'b0;
			stop_q   <= 1'b0;
			run_ms_q <= '0;
			pe_q     <= '0;
			ue_q     <= '0;
			out_q    <= 1'b0;
			grn_q    <= 1'b0;
			org_q    <= 1'b0;
			red_q    <= 1'b0;
		end else if (adv) begin
			ph_q     <= ph_n;
			start_q  <= start_n;
			stop_q   <= stop_n;
			run_ms_q <= run_ms_n;
			pe_q     <= pe_n;
			ue_q     <= ue_n;
			out_q    <= out_n;
			grn_q    <= grn_n;
			org_q    <= org_n;
			red_q    <= red_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2.output_on      <= out_n;
			res_s2.led_green      <= grn_n;
			res_s2.led_orange     <= org_n;
			res_s2.led_red        <= red_n;
			res_s2.modem_event    <= ev_n;
			res_s2.program_active <= start_n;
			diff_s2               <= run_ms_n - pe_n;
		end
	end

	a_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_IDLE |-> !out_q && !grn_q && !org_q && !red_q)
		else $error("idle phase with output or lamps on");

	a_dial_clears: assert property (@(posedge clk) disable iff (!arst_n)
		$past(adv) && res_s2.modem_event == EV_DIAL |->
		!res_s2.output_on && !res_s2.led_green && !res_s2.led_orange && !res_s2.led_red)
		else $error("dial word with output or lamps on");

	a_hangup_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$past(adv) && res_s2.modem_event == EV_HANGUP |->
		ph_q == PH_IDLE && !res_s2.program_active)
		else $error("hang-up word without return to idle");

endmodule

// ----- hdl/tlcs_div.sv -----
// Minutes-left stage: divide the remaining milliseconds by 60000.
module tlcs_div (
	input  logic                      clk,
	input  logic                      en,
	input  logic [tlcs_pkg::CNT_W-1:0] diff,
	output logic [tlcs_pkg::MIN_W-1:0] minutes_q
);
	import tlcs_pkg::*;

	logic [CNT_W-DIV_PRE-1:0]    num;
	logic [CNT_W-DIV_PRE+27:0]   prod;

	assign num  = diff[CNT_W-1:DIV_PRE];
	assign prod = (CNT_W-DIV_PRE+28)'(num) * (CNT_W-DIV_PRE+28)'(RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			minutes_q <= prod[DIV_SHIFT+MIN_W-1:DIV_SHIFT];
		end
	end

endmodule

// ----- hdl/timed_lock_call_sequencer_unit.sv -----
// Top level of the timed lock call sequencer: handshake, registers, pipeline.
// Pipeline: input register, step stage result register, then output register and minutes divider.
// Throughput: one word per cycle while out_stall lets words drain; the phase
// update closes through the state registers of the step stage.
// Reset: arst_n clears phase, flags, timers and lamps and loads the timeout
// registers with their defaults; the pipeline comes up empty.
module timed_lock_call_sequencer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  command,
	input  logic [15:0]                 duration_min,
	input  logic                        locked,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        output_on,
	output logic                        led_green,
	output logic                        led_orange,
	output logic                        led_red,
	output logic [1:0]                  modem_event,
	output logic                        program_active,
	output logic [15:0]                 minutes_left,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_index,
	input  logic [tlcs_pkg::CFG_W-1:0]  cfg_data
);
	import tlcs_pkg::*;

	cfg_t             cfg_q;
	logic             v1_q;
	logic             v2_q;
	logic             v3_q;
	logic             en2;
	logic             en3;
	logic [1:0]       cmd_s1;
	logic [CNT_W-1:0] dur_ms_s1;
	logic             locked_s1;
	res_t             res_s2;
	res_t             res_s3;
	logic [CNT_W-1:0] diff_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lock_to   <= LOCK_TO_RST;
			cfg_q.unlock_to <= UNLOCK_TO_RST;
			cfg_q.hangup_to <= HANGUP_TO_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_LOCK_TO:   cfg_q.lock_to   <= cfg_data;
				REG_UNLOCK_TO: cfg_q.unlock_to <= cfg_data;
				REG_HANGUP_TO: cfg_q.hangup_to <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en3      = !v3_q || !out_stall;
	assign en2      = !v2_q || en3;
	assign in_stall = v1_q && !en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (!in_stall) v1_q <= in_valid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1    <= command;
			dur_ms_s1 <= CNT_W'(duration_min) * MS_PER_MIN;
			locked_s1 <= locked;
		end
	end

	tlcs_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (v1_q && en2),
		.cfg       (cfg_q),
		.cmd_s1    (cmd_s1),
		.dur_ms_s1 (dur_ms_s1),
		.locked_s1 (locked_s1),
		.res_s2    (res_s2),
		.diff_s2   (diff_s2)
	);

	tlcs_div u_div (
		.clk       (clk),
		.en        (v2_q && en3),
		.diff      (diff_s2),
		.minutes_q (minutes_left)
	);

	always_ff @(posedge clk) begin
		if (v2_q && en3) begin
			res_s3 <= res_s2;
		end
	end

	assign out_valid      = v3_q;
	assign output_on      = res_s3.output_on;
	assign led_green      = res_s3.led_green;
	assign led_orange     = res_s3.led_orange;
	assign led_red        = res_s3.led_red;
	assign modem_event    = res_s3.modem_event;
	assign program_active = res_s3.program_active;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v1_q && v2_q && v3_q && out_stall)
		else $error("input stalled with room in the pipeline");

	a_hold_mid: assert property (@(posedge clk) disable iff (!arst_n)
		v2_q && v3_q && out_stall |=> v2_q && $stable(diff_s2))
		else $error("middle stage word lost under stall");

endmodule

// ----- bench/tlcs_checker.sv -----
// Checker for the timed lock call sequencer: tick prediction and result word comparison.
module tlcs_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [1:0]                 command,
	input  logic [15:0]                duration_min,
	input  logic                       locked,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       output_on,
	input  logic                       led_green,
	input  logic                       led_orange,
	input  logic                       led_red,
	input  logic [1:0]                 modem_event,
	input  logic                       program_active,
	input  logic [15:0]                minutes_left,
	input  logic                       cfg_wr_en,
	input  logic [1:0]                 cfg_index,
	input  logic [tlcs_pkg::CFG_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         outstanding,
	output int                         words_checked,
	output int                         dial_count,
	output int                         hangup_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import tlcs_pkg::*;

	localparam int LAMP_G = 0;
	localparam int LAMP_O = 1;
	localparam int LAMP_R = 2;

	typedef struct packed {
		res_t        flags;
		logic [15:0] minutes_left;
	} tick_word_t;

	logic [CFG_W-1:0] lock_to;
	logic [CFG_W-1:0] unlock_to;
	logic [CFG_W-1:0] hangup_to;

	logic [1:0]       phase;
	logic             start_pend;
	logic             stop_pend;
	logic [15:0]      run_min;
	logic [CNT_W-1:0] ph_elapsed;
	logic [CNT_W-1:0] unl_elapsed;
	logic             out_lvl;
	logic [2:0]       lamps;

	tick_word_t tick_words_due[$];

	function automatic void drop_to_idle();
		out_lvl = 1'b0;
		lamps = '0;
		phase = PH_IDLE;
		start_pend = 1'b0;
		stop_pend = 1'b0;
	endfunction

	function automatic tick_word_t advance_tick(logic [1:0] cmd, logic [15:0] dur, logic lk);
		tick_word_t w;
		logic [1:0] ev;
		logic [CNT_W-1:0] run_ms;
		logic [CNT_W-1:0] left;
		ev = EV_NONE;
		if (ph_elapsed != '1) ph_elapsed++;
		if (unl_elapsed != '1) unl_elapsed++;
		case (cmd)
			CMD_START: begin
				run_min = dur;
				start_pend = 1'b1;
			end
			CMD_STOP: stop_pend = 1'b1;
			default: ;
		endcase
		if (phase == PH_IDLE && start_pend) begin
			stop_pend = 1'b0;
			lamps[LAMP_G] = 1'b1;
			phase = PH_WAIT;
			ph_elapsed = '0;
		end
		if (phase == PH_WAIT) begin
			if (stop_pend || ph_elapsed >= {8'd0, lock_to}) begin
				drop_to_idle();
			end else if (lk) begin
				phase = PH_RUN;
				lamps[LAMP_O] = 1'b1;
				ph_elapsed = '0;
				unl_elapsed = '0;
			end
		end
		run_ms = run_min * MS_PER_MIN;
		if (phase == PH_RUN) begin
			if (stop_pend) begin
				drop_to_idle();
			end else begin
				out_lvl = lk;
				if (lk) begin
					unl_elapsed = '0;
					lamps[LAMP_R] = 1'b1;
				end
				if (ph_elapsed >= run_ms || unl_elapsed >= {8'd0, unlock_to}) begin
					out_lvl = 1'b0;
					lamps = '0;
					ev = EV_DIAL;
					ph_elapsed = '0;
					phase = PH_CALL;
				end
			end
		end else if (phase == PH_CALL && ev == EV_NONE) begin
			if (ph_elapsed >= {8'd0, hangup_to}) begin
				ev = EV_HANGUP;
				start_pend = 1'b0;
				phase = PH_IDLE;
			end
		end
		left = (run_ms - ph_elapsed) / MS_PER_MIN;
		w.flags.output_on = out_lvl;
		w.flags.led_green = lamps[LAMP_G];
		w.flags.led_orange = lamps[LAMP_O];
		w.flags.led_red = lamps[LAMP_R];
		w.flags.modem_event = ev;
		w.flags.program_active = start_pend;
		w.minutes_left = left[15:0];
		return w;
	endfunction

	function automatic void check_field(string name, logic [15:0] exp_val, logic [15:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_word_t due;
		if (!arst_n) begin
			lock_to = LOCK_TO_RST;
			unlock_to = UNLOCK_TO_RST;
			hangup_to = HANGUP_TO_RST;
			phase = PH_IDLE;
			start_pend = 1'b0;
			stop_pend = 1'b0;
			run_min = '0;
			ph_elapsed = '0;
			unl_elapsed = '0;
			out_lvl = 1'b0;
			lamps = '0;
			tick_words_due.delete();
			fail_count = 0;
			words_checked = 0;
			dial_count = 0;
			hangup_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_LOCK_TO:   lock_to = cfg_data;
					REG_UNLOCK_TO: unlock_to = cfg_data;
					REG_HANGUP_TO: hangup_to = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				tick_words_due.push_back(advance_tick(command, duration_min, locked));
			if (out_valid && !out_stall) begin
				if (tick_words_due.size() == 0) begin
					$error("result word with no tick pending");
					fail_count++;
				end else begin
					due = tick_words_due.pop_front();
					words_checked++;
					if (due.flags.modem_event == EV_DIAL) dial_count++;
					if (due.flags.modem_event == EV_HANGUP) hangup_count++;
					check_field("output_on", 16'(due.flags.output_on), 16'(output_on));
					check_field("led_green", 16'(due.flags.led_green), 16'(led_green));
					check_field("led_orange", 16'(due.flags.led_orange),
						16'(led_orange));
					check_field("led_red", 16'(due.flags.led_red), 16'(led_red));
					check_field("modem_event", 16'(due.flags.modem_event),
						16'(modem_event));
					check_field("program_active", 16'(due.flags.program_active),
						16'(program_active));
					check_field("minutes_left", due.minutes_left, minutes_left);
				end
			end
			outstanding <= tick_words_due.size();
		end
	end

endmodule

// ----- bench/timed_lock_call_sequencer_unit_tb.sv -----
// Testbench top for the timed lock call sequencer: clock, reset, stimulus and verdict.
module timed_lock_call_sequencer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tlcs_pkg::*;

	localparam logic [1:0]       CMD_TICK   = 2'd0;
	localparam logic [1:0]       CMD_RSVD   = 2'd3;
	localparam logic [1:0]       REG_NONE   = 2'd3;
	localparam logic [CFG_W-1:0] CFG_MAX    = '1;
	localparam int               LONG_HOLD  = 64;
	localparam int               CYCLE_LIMIT = 200000;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       command;
	logic [15:0]      duration_min;
	logic             locked;
	logic             out_valid;
	logic             out_stall;
	logic             output_on;
	logic             led_green;
	logic             led_orange;
	logic             led_red;
	logic [1:0]       modem_event;
	logic             program_active;
	logic [15:0]      minutes_left;
	logic             cfg_wr_en;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	int  fail_count;
	int  outstanding;
	int  words_checked;
	int  dial_count;
	int  hangup_count;
	int  cycle_count;
	int  ticks_sent;
	int  burst_left;
	int  lock_bias;
	bit  want_long_hold;
	bit  long_hold_done;

	timed_lock_call_sequencer_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.duration_min   (duration_min),
		.locked         (locked),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.output_on      (output_on),
		.led_green      (led_green),
		.led_orange     (led_orange),
		.led_red        (led_red),
		.modem_event    (modem_event),
		.program_active (program_active),
		.minutes_left   (minutes_left),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	tlcs_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.duration_min   (duration_min),
		.locked         (locked),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.output_on      (output_on),
		.led_green      (led_green),
		.led_orange     (led_orange),
		.led_red        (led_red),
		.modem_event    (modem_event),
		.program_active (program_active),
		.minutes_left   (minutes_left),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.outstanding    (outstanding),
		.words_checked  (words_checked),
		.dial_count     (dial_count),
		.hangup_count   (hangup_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		int mode;
		int len;
		out_stall = 1'b0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (want_long_hold && !long_hold_done) begin
				out_stall <= 1'b1;
				for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
				long_hold_done = 1'b1;
			end else begin
				mode = $urandom_range(0, 3);
				len = $urandom_range(5, 40);
				for (int n = 0; n < len; n++) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 3) == 0);
						2: out_stall <= 1'($urandom_range(0, 1));
						default: out_stall <= ($urandom_range(0, 3) != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	task automatic send_word(logic [1:0] cmd, logic [15:0] dur, logic lk);
		in_valid <= 1'b1;
		command <= cmd;
		duration_min <= dur;
		locked <= lk;
		do @(posedge clk); while (in_stall);
		ticks_sent++;
	endtask

	task automatic pace();
		int gap;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			burst_left = $urandom_range(1, 30);
			case ($urandom_range(0, 2))
				0: lock_bias = 10;
				1: lock_bias = 50;
				default: lock_bias = 90;
			endcase
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold input until every pending result word is back, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic program_regs(logic [CFG_W-1:0] lock_to, logic [CFG_W-1:0] unlock_to,
			logic [CFG_W-1:0] hangup_to);
		write_reg(REG_LOCK_TO, lock_to);
		write_reg(REG_UNLOCK_TO, unlock_to);
		write_reg(REG_HANGUP_TO, hangup_to);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_random(int count);
		int r;
		logic [1:0] cmd;
		logic [15:0] dur;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) cmd = CMD_START;
			else if (r < 11) cmd = CMD_STOP;
			else if (r < 13) cmd = CMD_RSVD;
			else cmd = CMD_TICK;
			r = $urandom_range(0, 9);
			if (r < 4) dur = '0;
			else if (r < 7) dur = 16'($urandom_range(1, 3));
			else dur = 16'($urandom);
			send_word(cmd, dur, $urandom_range(0, 99) < lock_bias);
			pace();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_TICK;
		duration_min = '0;
		locked = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_LOCK_TO;
		cfg_data = '0;
		want_long_hold = 1'b0;
		ticks_sent = 0;
		burst_left = 0;
		lock_bias = 50;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset timeouts, reserved code, stray stop, start while running
		send_word(CMD_TICK, 16'h0000, 1'b0);
		send_word(CMD_RSVD, 16'hFFFF, 1'b1);
		send_word(CMD_STOP, 16'h0000, 1'b0);
		send_word(CMD_START, 16'hFFFF, 1'b0);
		send_word(CMD_TICK, 16'h0000, 1'b1);
		send_word(CMD_TICK, 16'h0000, 1'b0);
		send_word(CMD_START, 16'h0000, 1'b1);
		send_word(CMD_STOP, 16'h0000, 1'b0);
		send_word(CMD_TICK, 16'h0000, 1'b1);
		drain();
		program_regs(LOCK_TO_RST, UNLOCK_TO_RST, '0);
		send_word(CMD_TICK, 16'h0000, 1'b0);
		send_word(CMD_START, 16'h0001, 1'b0);
		send_word(CMD_STOP, 16'h0000, 1'b0);
		drain();
		program_regs('0, UNLOCK_TO_RST, '0);
		send_word(CMD_START, 16'h0005, 1'b1);
		drain();
		program_regs(CFG_MAX, '0, '0);
		send_word(CMD_START, 16'h0002, 1'b1);
		send_word(CMD_TICK, 16'h0000, 1'b0);
		send_word(CMD_START, 16'h0003, 1'b0);
		send_word(CMD_TICK, 16'h0000, 1'b1);
		send_word(CMD_TICK, 16'h0000, 1'b0);
		drain();
		write_reg(REG_NONE, '0);
		program_regs(CFG_MAX, CFG_MAX, '0);
		send_word(CMD_START, 16'h0001, 1'b1);
		send_word(CMD_STOP, 16'h0000, 1'b1);
		send_word(CMD_TICK, 16'h0000, 1'b0);
		drain();

		program_regs(CFG_W'($urandom_range(0, 10)), CFG_W'($urandom_range(0, 10)),
			CFG_W'($urandom_range(0, 10)));
		want_long_hold <= 1'b1;
		run_random(140);
		drain();
		program_regs(CFG_W'($urandom_range(0, 10)), CFG_W'($urandom_range(0, 10)),
			CFG_W'($urandom_range(0, 10)));
		run_random(140);
		drain();
		program_regs('0, '0, '0);
		run_random(60);
		drain();
		program_regs(CFG_MAX, CFG_MAX, CFG_MAX);
		run_random(60);
		drain();
		repeat (10) @(posedge clk);

		$display("%0d ticks driven, %0d result words compared", ticks_sent, words_checked);
		$display("%0d dial and %0d hang-up events over default, small, zero and full timeouts",
			dial_count, hangup_count);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/tlcs_pkg.sv
hdl/tlcs_step.sv
hdl/tlcs_div.sv
hdl/timed_lock_call_sequencer_unit.sv
bench/tlcs_checker.sv
bench/timed_lock_call_sequencer_unit_tb.sv
